// File: rtl/dcal_pkg.sv
package dcal_pkg;

  localparam int OFFSET_W = 21;
  localparam int FRAC_W   = 16;
  localparam int REM_W    = 22;
  localparam int SECS_W   = 17;
  localparam int YEAR_W   = 14;
  localparam int CNT_W    = 5;

  // Day count from 1 March of year -1200 to 1 January 2000.
  localparam logic [REM_W-1:0]  Z_BASE     = 22'd1168716;
  localparam logic [YEAR_W-1:0] YEAR_START = 14'(-1200);

  localparam logic [REM_W-1:0] DAYS_ERA  = 22'd146097;
  localparam logic [REM_W-1:0] DAYS_CENT = 22'd36524;
  localparam logic [REM_W-1:0] DAYS_QUAD = 22'd1461;
  localparam logic [REM_W-1:0] DAYS_YEAR = 22'd365;
  localparam logic [REM_W-1:0] SECS_HOUR = 22'd3600;
  localparam logic [REM_W-1:0] SECS_TMIN = 22'd600;
  localparam logic [REM_W-1:0] SECS_MIN  = 22'd60;

  localparam logic [9:0] SECS_MUL   = 10'd675;
  localparam logic [8:0] SECS_ROUND = 9'd256;

  typedef struct packed {
    logic idle;
    logic done;
  } dcal_status_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } dcal_result_t;

  // Month lengths counted from March; February comes last and is never stepped past.
  function automatic logic [4:0] month_len(input logic [3:0] idx);
    logic [4:0] len;
    case (idx)
      4'd1, 4'd3, 4'd6, 4'd8: len = 5'd30;
      4'd11:                  len = 5'd29;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/day_number_to_calendar_date.sv
// Converts a signed day count relative to 1 January 2000 and a Q0.16 day
// fraction into a Gregorian date and a time of day rounded to the nearest
// second. A single shared subtractor takes one step per cycle, removing
// 400-year eras, centuries, four-year groups, years and months, and then
// hours, tens of minutes and minutes, so the time between acceptances
// follows how many steps the input needs. The block takes no new item
// while one is in work, but a finished result waits in the output register
// while the next item is accepted.
module day_number_to_calendar_date (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // day_offset[20:0], day_fraction[36:21], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // year_out, month_out, day_out, hour_out,
                                 // minute_out, second_out, zero fill
);
  import dcal_pkg::*;

  dcal_status_t status;
  dcal_result_t result;
  logic         start;
  logic         take;

  assign s_tready = status.idle && !rst;
  assign start    = s_tvalid && s_tready;
  assign take     = status.done && (!m_tvalid || m_tready);

  dcal_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .offset (s_tdata[OFFSET_W-1:0]),
    .frac   (s_tdata[OFFSET_W+FRAC_W-1:OFFSET_W]),
    .take   (take),
    .status (status),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {2'b00, result.second, result.minute, result.hour,
                  result.day, result.month, result.year};
    end
  end

endmodule

// File: rtl/dcal_sub.sv
module dcal_sub (
  input  logic [dcal_pkg::REM_W-1:0] a,
  input  logic [dcal_pkg::REM_W-1:0] b,
  output logic [dcal_pkg::REM_W-1:0] diff,
  output logic                       ge
);
  import dcal_pkg::*;

  logic borrow;

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = !borrow;

endmodule

// File: rtl/dcal_ctrl.sv
module dcal_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [dcal_pkg::OFFSET_W-1:0] offset,
  input  logic [dcal_pkg::FRAC_W-1:0]        frac,
  input  logic                               take,
  output dcal_pkg::dcal_status_t             status,
  output dcal_pkg::dcal_result_t             result
);
  import dcal_pkg::*;

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_ERA  = 4'd1;
  localparam logic [3:0] PH_CENT = 4'd2;
  localparam logic [3:0] PH_QUAD = 4'd3;
  localparam logic [3:0] PH_YEAR = 4'd4;
  localparam logic [3:0] PH_MON  = 4'd5;
  localparam logic [3:0] PH_HOUR = 4'd6;
  localparam logic [3:0] PH_TMIN = 4'd7;
  localparam logic [3:0] PH_MIN  = 4'd8;
  localparam logic [3:0] PH_DONE = 4'd9;

  logic [3:0]        phase;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W-1:0]  rem;
  logic [SECS_W-1:0] secs;
  logic [YEAR_W-1:0] year;
  logic [3:0]        month;
  logic [4:0]        day;
  logic [4:0]        hour;
  logic [5:0]        minute;
  logic [5:0]        second;

  logic [REM_W-1:0]  sub_val;
  logic [CNT_W-1:0]  limit;
  logic [REM_W-1:0]  diff;
  logic              ge;
  logic              step;
  logic [25:0]       prod;

  dcal_sub u_sub (
    .a    (rem),
    .b    (sub_val),
    .diff (diff),
    .ge   (ge)
  );

  always_comb begin
    unique case (phase)
      PH_ERA: begin
        sub_val = DAYS_ERA;
        limit   = 5'd31;
      end
      PH_CENT: begin
        sub_val = DAYS_CENT;
        limit   = 5'd3;
      end
      PH_QUAD: begin
        sub_val = DAYS_QUAD;
        limit   = 5'd24;
      end
      PH_YEAR: begin
        sub_val = DAYS_YEAR;
        limit   = 5'd3;
      end
      PH_MON: begin
        sub_val = {17'd0, month_len(cnt[3:0])};
        limit   = 5'd11;
      end
      PH_HOUR: begin
        sub_val = SECS_HOUR;
        limit   = 5'd31;
      end
      PH_TMIN: begin
        sub_val = SECS_TMIN;
        limit   = 5'd31;
      end
      PH_MIN: begin
        sub_val = SECS_MIN;
        limit   = 5'd31;
      end
      default: begin
        sub_val = '0;
        limit   = '0;
      end
    endcase
  end

  assign step = ge && (cnt < limit);
  assign prod = frac * SECS_MUL + {17'd0, SECS_ROUND};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            rem    <= {offset[OFFSET_W-1], offset} + Z_BASE;
            secs   <= prod[25:9];
            year   <= YEAR_START;
            hour   <= '0;
            minute <= '0;
            cnt    <= '0;
            phase  <= PH_ERA;
          end
        end
        PH_DONE: begin
          if (take) begin
            phase <= PH_IDLE;
          end
        end
        default: begin
          if (step) begin
            rem <= diff;
            cnt <= cnt + 5'd1;
            case (phase)
              PH_ERA:  year   <= year + 14'd400;
              PH_CENT: year   <= year + 14'd100;
              PH_QUAD: year   <= year + 14'd4;
              PH_YEAR: year   <= year + 14'd1;
              PH_HOUR: hour   <= hour + 5'd1;
              PH_TMIN: minute <= minute + 6'd10;
              PH_MIN:  minute <= minute + 6'd1;
              default: ;
            endcase
          end else begin
            cnt <= '0;
            case (phase)
              PH_ERA:  phase <= PH_CENT;
              PH_CENT: phase <= PH_QUAD;
              PH_QUAD: phase <= PH_YEAR;
              PH_YEAR: phase <= PH_MON;
              PH_MON: begin
                day <= rem[4:0] + 5'd1;
                if (cnt < 5'd10) begin
                  month <= cnt[3:0] + 4'd3;
                end else begin
                  month <= cnt[3:0] - 4'd9;
                  year  <= year + 14'd1;
                end
                rem   <= {5'd0, secs};
                phase <= PH_HOUR;
              end
              PH_HOUR: phase <= PH_TMIN;
              PH_TMIN: phase <= PH_MIN;
              default: begin
                second <= rem[5:0];
                phase  <= PH_DONE;
              end
            endcase
          end
        end
      endcase
    end
  end

  assign status.idle = (phase == PH_IDLE);
  assign status.done = (phase == PH_DONE);

  assign result.year   = year[11:0];
  assign result.month  = month;
  assign result.day    = day;
  assign result.hour   = hour;
  assign result.minute = minute;
  assign result.second = second;

endmodule
